/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check: when the antecedent holds, the consequent holds in the same cycle.
`define SLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequential list engine check failed");

// Concurrent check: when the antecedent holds, the consequent holds in the following cycle.
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequential list engine check failed");

`endif

/* hw/rtl/sle_pkg.sv */
package sle_pkg;

   localparam int MODE_W     = 3;
   localparam int POS_W      = 8;
   localparam int VAL_W      = 32;
   localparam int STATUS_W   = 2;
   // Number of cells the scanner examines per cycle; a power of two.
   localparam int SCAN_WIDTH = 16;
   localparam int SCAN_IDX_W = $clog2(SCAN_WIDTH);

   localparam logic [MODE_W-1:0] MODE_GET    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOCATE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Command broadcast to every cell of the chain at once.
   typedef struct packed {
      logic             insert;
      logic             remove;
      logic             probe;
      logic             probe_get;
      logic [POS_W-1:0] slot;
      logic [POS_W-1:0] count;
      logic [VAL_W-1:0] value;
   } sle_cell_ctrl_type;

   // Outcome of one scan over the hit flags of the chain.
   typedef struct packed {
      logic             done;
      logic [POS_W-1:0] found;
      logic [VAL_W-1:0] value;
   } sle_scan_result_type;

endpackage

/* hw/rtl/sle_req_if.sv */
interface sle_req_if
   import sle_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic [MODE_W-1:0]       mode;
   logic [POS_W-1:0]        position;
   logic signed [VAL_W-1:0] item_value;

   modport source (output valid, output mode, output position, output item_value,
                   input ready);
   modport sink (input valid, input mode, input position, input item_value,
                 output ready);
endinterface

/* hw/rtl/sle_rsp_if.sv */
interface sle_rsp_if
   import sle_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic [POS_W-1:0]        found_position;
   logic signed [VAL_W-1:0] read_value;
   logic [POS_W-1:0]        list_length;

   modport source (output valid, output status, output found_position,
                   output read_value, output list_length, input ready);
   modport sink (input valid, input status, input found_position,
                 input read_value, input list_length, output ready);
endinterface

/* hw/rtl/sequential_list_engine.sv */
// Sequential list engine: an ordered list of up to CAPACITY signed 32-bit values,
// positions counted from 1. Items arrive on the req_chan channel (mode, position,
// item_value) and each item gives exactly one item on the rsp_chan channel (status,
// found_position, read_value, list_length). Both channels use valid/ready.
// The list lives in a chain of cells, one entry per cell. Insert and delete move
// every later entry to its neighbor at once, so insert, delete, clear, unused modes
// and any rejected item go from decode straight to the answer hold state. Get and
// locate probe all cells at once, then a scanner walks the hit flags 16 cells per
// cycle; their answer waits on the number of scanner groups visited before the
// first hit.
// One item is worked at a time: the next item may be accepted from the cycle after
// the previous answer moves to the output register.
// Reset empties the list and drops any pending answer. When the receiver stalls,
// the answer waits in the output register and one more item may be accepted and
// worked; its answer is held until the output register is free.
`include "assert_macros.svh"

module sequential_list_engine
   import sle_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  logic       clock,
   input  logic       reset,
   sle_req_if.sink    req_chan,
   sle_rsp_if.source  rsp_chan
);

   localparam int GROUPS = (CAPACITY + SCAN_WIDTH - 1) / SCAN_WIDTH;
   localparam logic [POS_W-1:0] CAP_COUNT = POS_W'(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;

   // Length of the list; cells at or above it hold stale data.
   logic [POS_W-1:0]    count_ff, count_in;

   // The accepted item.
   logic [MODE_W-1:0]   req_mode_ff, req_mode_in;
   logic [POS_W-1:0]    req_pos_ff, req_pos_in;
   logic [VAL_W-1:0]    req_value_ff, req_value_in;

   // Answer of the current item, waiting for the output register.
   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [POS_W-1:0]    pend_found_ff, pend_found_in;
   logic [VAL_W-1:0]    pend_value_ff, pend_value_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]    rsp_found_ff, rsp_found_in;
   logic [VAL_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]    rsp_length_ff, rsp_length_in;

   sle_cell_ctrl_type   cell_ctrl;
   sle_scan_result_type scan_result;

   logic [VAL_W-1:0] cell_value [CAPACITY];
   logic [GROUPS-1:0][SCAN_WIDTH-1:0]            hit_grid;
   logic [GROUPS-1:0][SCAN_WIDTH-1:0][VAL_W-1:0] masked_grid;

   logic [POS_W:0] pos_wide;
   logic [POS_W:0] count_wide;
   logic           pos_nonzero;
   logic           get_ok;
   logic           insert_ok;

   // Range checks are made on one extra bit so that length + 1 cannot wrap.
   assign pos_wide    = {1'b0, req_pos_ff};
   assign count_wide  = {1'b0, count_ff};
   assign pos_nonzero = (req_pos_ff != '0);
   assign get_ok      = pos_nonzero && (pos_wide <= count_wide);
   assign insert_ok   = pos_nonzero && (pos_wide <= (count_wide + (POS_W + 1)'(1)));

   // Control: decode the accepted item in ST_EXEC, then either finish it
   // at once or wait for the scanner, and finally hand the answer over.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      req_mode_in    = req_mode_ff;
      req_pos_in     = req_pos_ff;
      req_value_in   = req_value_ff;
      pend_status_in = pend_status_ff;
      pend_found_in  = pend_found_ff;
      pend_value_in  = pend_value_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_length_in  = rsp_length_ff;

      cell_ctrl           = '0;
      cell_ctrl.slot      = req_pos_ff - POS_W'(1);
      cell_ctrl.count     = count_ff;
      cell_ctrl.value     = req_value_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               req_mode_in  = req_chan.mode;
               req_pos_in   = req_chan.position;
               req_value_in = req_chan.item_value;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            pend_status_in = STATUS_OK;
            pend_found_in  = '0;
            pend_value_in  = '0;
            state_in       = ST_HOLD;
            case (req_mode_ff)
               MODE_GET: begin
                  if (get_ok) begin
                     cell_ctrl.probe     = 1'b1;
                     cell_ctrl.probe_get = 1'b1;
                     state_in            = ST_SCAN;
                  end else begin
                     pend_status_in = STATUS_RANGE;
                  end
               end
               MODE_LOCATE: begin
                  cell_ctrl.probe = 1'b1;
                  state_in        = ST_SCAN;
               end
               MODE_INSERT: begin
                  if (!insert_ok) begin
                     pend_status_in = STATUS_RANGE;
                  end else if (count_ff == CAP_COUNT) begin
                     pend_status_in = STATUS_FULL;
                  end else begin
                     cell_ctrl.insert = 1'b1;
                     count_in         = count_ff + POS_W'(1);
                  end
               end
               MODE_DELETE: begin
                  if (get_ok) begin
                     cell_ctrl.remove = 1'b1;
                     count_in         = count_ff - POS_W'(1);
                  end else begin
                     pend_status_in = STATUS_RANGE;
                  end
               end
               MODE_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  // Unused modes leave the list alone and report success.
               end
            endcase
         end
         ST_SCAN: begin
            if (scan_result.done) begin
               // Locate reports only the position; get reports only the value.
               pend_found_in = (req_mode_ff == MODE_LOCATE) ? scan_result.found : '0;
               pend_value_in = (req_mode_ff == MODE_GET) ? scan_result.value : '0;
               state_in      = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_found_in  = pend_found_ff;
               rsp_value_in  = pend_value_ff;
               rsp_length_in = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_mode_ff    <= req_mode_in;
      req_pos_ff     <= req_pos_in;
      req_value_ff   <= req_value_in;
      pend_status_ff <= pend_status_in;
      pend_found_ff  <= pend_found_in;
      pend_value_ff  <= pend_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_length_ff  <= rsp_length_in;
   end

   // The chain: each cell sees its two neighbors. The ends are tied off since an
   // insert never pulls into the first cell and a delete leaves the last one stale.
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [VAL_W-1:0] left_value;
      logic [VAL_W-1:0] right_value;

      if (k == 0) begin : g_head
         assign left_value = '0;
      end else begin : g_left
         assign left_value = cell_value[k-1];
      end
      if (k == CAPACITY - 1) begin : g_tail
         assign right_value = '0;
      end else begin : g_right
         assign right_value = cell_value[k+1];
      end

      sle_cell #(
         .INDEX(k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .left_value  (left_value),
         .right_value (right_value),
         .cell_value  (cell_value[k]),
         .cell_hit    (hit_grid[k / SCAN_WIDTH][k % SCAN_WIDTH]),
         .cell_masked (masked_grid[k / SCAN_WIDTH][k % SCAN_WIDTH])
      );
   end

   // Scanner slots beyond the last cell never hit.
   for (genvar k = CAPACITY; k < GROUPS * SCAN_WIDTH; k++) begin : g_pad
      assign hit_grid[k / SCAN_WIDTH][k % SCAN_WIDTH]    = 1'b0;
      assign masked_grid[k / SCAN_WIDTH][k % SCAN_WIDTH] = '0;
   end

   sle_scan #(
      .GROUPS(GROUPS)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (cell_ctrl.probe),
      .hits   (hit_grid),
      .masked (masked_grid),
      .result (scan_result)
   );

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.found_position = rsp_found_ff;
   assign rsp_chan.read_value    = rsp_value_ff;
   assign rsp_chan.list_length   = rsp_length_ff;

   // The list never grows past its capacity.
   `SLE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CAP_COUNT)
   // A successful insert lengthens the list by exactly one entry.
   `SLE_ASSERT_NEXT(a_insert_grows, clock, reset, cell_ctrl.insert,
                    count_ff == $past(count_ff) + POS_W'(1))
   // The scanner reports only while the controller waits for it.
   `SLE_ASSERT_NOW(a_scan_owner, clock, reset, scan_result.done, state_ff == ST_SCAN)
   // A freshly loaded answer carries the current list length.
   `SLE_ASSERT_NOW(a_length_match, clock, reset, $rose(rsp_valid_ff),
                   rsp_length_ff == count_ff)

endmodule

/* hw/rtl/sle_cell.sv */
module sle_cell
   import sle_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  sle_cell_ctrl_type ctrl,
   input  logic [VAL_W-1:0]  left_value,
   input  logic [VAL_W-1:0]  right_value,
   output logic [VAL_W-1:0]  cell_value,
   output logic              cell_hit,
   output logic [VAL_W-1:0]  cell_masked
);

   localparam logic [POS_W-1:0] SLOT_ID = POS_W'(INDEX);

   logic [VAL_W-1:0] value_ff, value_in;
   logic [VAL_W-1:0] masked_ff, masked_in;
   logic             hit_ff, hit_in;

   always_comb begin
      logic match;
      value_in  = value_ff;
      hit_in    = hit_ff;
      masked_in = masked_ff;
      match     = 1'b0;
      // Insert opens a gap at the slot by moving every later entry up one cell.
      if (ctrl.insert) begin
         if (SLOT_ID > ctrl.slot) begin
            value_in = left_value;
         end else if (SLOT_ID == ctrl.slot) begin
            value_in = ctrl.value;
         end
      end
      if (ctrl.remove && (SLOT_ID >= ctrl.slot)) begin
         value_in = right_value;
      end
      if (ctrl.probe) begin
         if (ctrl.probe_get) begin
            match = (SLOT_ID == ctrl.slot);
         end else begin
            match = (value_ff == ctrl.value) && (SLOT_ID < ctrl.count);
         end
         hit_in    = match;
         masked_in = match ? value_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      masked_ff <= masked_in;
   end

   assign cell_value  = value_ff;
   assign cell_hit    = hit_ff;
   assign cell_masked = masked_ff;

endmodule

/* hw/rtl/sle_scan.sv */
module sle_scan
   import sle_pkg::*;
#(
   parameter int GROUPS = 8
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  logic [GROUPS-1:0][SCAN_WIDTH-1:0]             hits,
   input  logic [GROUPS-1:0][SCAN_WIDTH-1:0][VAL_W-1:0]  masked,
   output sle_scan_result_type                           result
);

   localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam logic [GW-1:0] LAST_GROUP = GW'(GROUPS - 1);

   logic                busy_ff, busy_in;
   logic [GW-1:0]       group_ff, group_in;
   sle_scan_result_type result_ff, result_in;

   logic [SCAN_WIDTH-1:0] row_hits;
   logic                  row_any;
   logic [SCAN_IDX_W-1:0] row_idx;
   logic [VAL_W-1:0]      row_value;

   // Lowest set flag of the current group, and the OR of its masked values.
   always_comb begin
      row_hits  = hits[group_ff];
      row_any   = |row_hits;
      row_idx   = '0;
      row_value = '0;
      for (int i = SCAN_WIDTH - 1; i >= 0; i--) begin
         if (row_hits[i]) begin
            row_idx = SCAN_IDX_W'(i);
         end
      end
      for (int i = 0; i < SCAN_WIDTH; i++) begin
         row_value = row_value | masked[group_ff][i];
      end
   end

   always_comb begin
      busy_in        = busy_ff;
      group_in       = group_ff;
      result_in      = result_ff;
      result_in.done = 1'b0;
      if (start) begin
         busy_in  = 1'b1;
         group_in = '0;
      end else if (busy_ff) begin
         if (row_any || (group_ff == LAST_GROUP)) begin
            busy_in         = 1'b0;
            result_in.done  = 1'b1;
            result_in.found = row_any ? POS_W'({group_ff, row_idx}) + POS_W'(1) : '0;
            result_in.value = row_value;
         end else begin
            group_in = group_ff + GW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         group_ff       <= '0;
         result_ff.done <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         group_ff       <= group_in;
         result_ff.done <= result_in.done;
      end
      result_ff.found <= result_in.found;
      result_ff.value <= result_in.value;
   end

   assign result = result_ff;

endmodule
